>>> hdl/mmcs_pkg.sv
// Package for the min/max contrast stretch block.
// Holds frame and pixel sizes, derived widths and the divider result type.
// No dependencies.
package mmcs_pkg;

    localparam int FRAME_DEPTH = 4096;
    localparam int PIXEL_BITS  = 16;
    localparam int OUT_BITS    = 8;
    localparam int CFG_W       = 13;

    localparam int ADDR_W    = $clog2(FRAME_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int LEN_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int DIV_W     = PIXEL_BITS + OUT_BITS;
    localparam int DIV_CNT_W = $clog2(OUT_BITS + 1);

    localparam logic [CFG_W-1:0] PIX_TOTAL_RESET = CFG_W'(4096);

    typedef struct packed {
        logic                done;
        logic [OUT_BITS-1:0] quot;
    } div_res_t;

endpackage

>>> hdl/mmcs_if.sv
// Handshake channels of the contrast stretch block: request items in, results out.
// Depends on mmcs_pkg.
interface mmcs_in_if import mmcs_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

interface mmcs_out_if import mmcs_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] norm_pixel;
    logic                frame_end;

    modport source (output valid, output norm_pixel, output frame_end, input ready);
    modport sink   (input valid, input norm_pixel, input frame_end, output ready);
endinterface

>>> hdl/mmcs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mmcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/mmcs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Needs dividend < 2^OUT_BITS * divisor. Depends on mmcs_pkg.
module mmcs_div import mmcs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIV_W-1:0]      dividend,
    input  logic [PIXEL_BITS-1:0] divisor,
    output div_res_t              res
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [PIXEL_BITS-1:0] rem_reg;
    logic [PIXEL_BITS-1:0] dvs_reg;
    logic [OUT_BITS-1:0]   quo_reg;

    logic [PIXEL_BITS:0]   partial;
    logic [PIXEL_BITS:0]   diff;
    logic                  ge;
    logic [PIXEL_BITS-1:0] rem_next;

    assign partial  = {rem_reg, quo_reg[OUT_BITS-1]};
    assign ge       = partial >= {1'b0, dvs_reg};
    assign diff     = partial - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[PIXEL_BITS-1:0] : partial[PIXEL_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(OUT_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[DIV_W-1:OUT_BITS];
            quo_reg <= dividend[OUT_BITS-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[OUT_BITS-2:0], ge};
        end
    end

    assign res.done = done_reg;
    assign res.quot = quo_reg;

endmodule

>>> hdl/min_max_contrast_stretch_top.sv
// Top level of the min/max contrast stretch block.
// Depends on mmcs_pkg, mmcs_if, mmcs_ram and mmcs_div.
//
// Usage:
//   in_ch carries request items. req_type 0 loads pixel_in into the frame
//   store and updates the frame min/max; req_type 1 reads the next stored
//   pixel, stretched to floor(255*(p-min)/(max-min)), 0 for a flat frame.
//   Loads past the frame pixel total and reads before the frame is full are
//   dropped with no result. The read of the last pixel sets frame_end and
//   rearms the block for the next frame.
//   out_ch carries one result item per accepted read that is not dropped.
//   cfg_we/cfg_data write the frame pixel total (0 acts as 1, above
//   FRAME_DEPTH clamps); write it only while the block is idle.
// Timing:
//   A load leaves in_ch.ready high. A read is accepted in ST_IDLE (the store
//   read happens at the accepting edge) and goes through the offset/scale
//   state ST_PREP, the divider in ST_DIV (one quotient bit per cycle for
//   OUT_BITS bits), then ST_DONE and the output register; a flat frame skips
//   ST_DIV. in_ch.ready is low until the result is valid: reads do not overlap.
//   A stalled out_ch holds its item in an output register; loads and dropped
//   items still go through, a second read waits before the output register.
// Reset: pixel total returns to 4096, pointers clear, min/max trackers rearm.
//   Frame store contents are not cleared.
module min_max_contrast_stretch_top import mmcs_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    mmcs_in_if.sink          in_ch,
    mmcs_out_if.source       out_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CFG_W-1:0]      pix_total_reg;
    logic [PIXEL_BITS-1:0] min_reg;
    logic [PIXEL_BITS-1:0] max_reg;
    logic [CNT_W-1:0]      load_ptr_reg;
    logic [ADDR_W-1:0]     read_ptr_reg;
    logic                  last_reg;
    logic [OUT_BITS-1:0]   quot_reg;
    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   out_pix_reg;
    logic                  out_end_reg;

    logic [LEN_W-1:0]      pc_ext;
    logic [LEN_W-1:0]      n_len;
    logic                  frame_full;
    logic                  in_acc;
    logic                  ld_acc;
    logic                  rd_acc;
    logic                  out_free;
    logic                  out_load;
    logic [PIXEL_BITS-1:0] rdata;
    logic                  flat;
    logic [PIXEL_BITS-1:0] range_val;
    logic [PIXEL_BITS-1:0] off_raw;
    logic [PIXEL_BITS-1:0] off_val;
    logic [DIV_W-1:0]      dividend;
    logic                  div_start;
    div_res_t              div_res;

    assign pc_ext = LEN_W'(pix_total_reg);

    always_comb
    begin
        if (pc_ext == '0)
        begin
            n_len = LEN_W'(1);
        end
        else if (pc_ext > LEN_W'(FRAME_DEPTH))
        begin
            n_len = LEN_W'(FRAME_DEPTH);
        end
        else
        begin
            n_len = pc_ext;
        end
    end

    assign frame_full = LEN_W'(load_ptr_reg) >= n_len;
    assign in_acc     = in_ch.valid && in_ch.ready;
    assign ld_acc     = in_acc && !in_ch.req_type && !frame_full;
    assign rd_acc     = in_acc && in_ch.req_type && frame_full;
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign out_load   = (state_reg == ST_DONE) && out_free;

    mmcs_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ld_acc),
        .waddr (load_ptr_reg[ADDR_W-1:0]),
        .wdata (in_ch.pixel_in),
        .raddr (read_ptr_reg),
        .rdata (rdata)
    );

    assign flat      = max_reg <= min_reg;
    assign range_val = max_reg - min_reg;
    assign off_raw   = (rdata > min_reg) ? (rdata - min_reg) : '0;
    assign off_val   = (off_raw > range_val) ? range_val : off_raw;
    assign dividend  = {off_val, OUT_BITS'(0)} - DIV_W'(off_val);
    assign div_start = (state_reg == ST_PREP) && !flat;

    mmcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (range_val),
        .res      (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rd_acc)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = flat ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pix_total_reg <= PIX_TOTAL_RESET;
            min_reg       <= '1;
            max_reg       <= '0;
            load_ptr_reg  <= '0;
            read_ptr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                pix_total_reg <= cfg_data;
            end
            if (ld_acc)
            begin
                load_ptr_reg <= load_ptr_reg + 1'b1;
                if (in_ch.pixel_in < min_reg)
                begin
                    min_reg <= in_ch.pixel_in;
                end
                if (in_ch.pixel_in > max_reg)
                begin
                    max_reg <= in_ch.pixel_in;
                end
            end
            else if (out_load)
            begin
                if (last_reg)
                begin
                    min_reg      <= '1;
                    max_reg      <= '0;
                    load_ptr_reg <= '0;
                    read_ptr_reg <= '0;
                end
                else
                begin
                    read_ptr_reg <= read_ptr_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_acc)
        begin
            last_reg <= LEN_W'(read_ptr_reg) >= (n_len - LEN_W'(1));
        end
        if ((state_reg == ST_PREP) && flat)
        begin
            quot_reg <= '0;
        end
        else if ((state_reg == ST_DIV) && div_res.done)
        begin
            quot_reg <= div_res.quot;
        end
        if (out_load)
        begin
            out_pix_reg <= quot_reg;
            out_end_reg <= last_reg;
        end
    end

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.norm_pixel = out_pix_reg;
    assign out_ch.frame_end  = out_end_reg;

endmodule

>>> hdl/mmcs_checker.sv
// Port-level checks for the contrast stretch block, bound to the top level.
// Depends on mmcs_pkg and min_max_contrast_stretch_top.
module mmcs_checker import mmcs_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                in_req_type,
    input logic                out_valid,
    input logic                out_ready,
    input logic [OUT_BITS-1:0] out_norm_pixel,
    input logic                out_frame_end
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_norm_pixel) && $stable(out_frame_end))
        else $error("result payload changed while stalled");

    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_req_type |=> in_ready)
        else $error("load item left block busy");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result item without a read in flight");

endmodule

bind min_max_contrast_stretch_top mmcs_checker u_mmcs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_req_type    (in_ch.req_type),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_norm_pixel (out_ch.norm_pixel),
    .out_frame_end  (out_ch.frame_end)
);

>>> tb/sv/mmcs_tb_pkg.sv
// Request codes shared by the contrast stretch testbench files.
// No dependencies.
package mmcs_tb_pkg;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

endpackage

>>> tb/sv/stretch_result_check.sv
// Result checker for the min/max contrast stretch block: tracks the frame store,
// min/max and pointers from accepted items, predicts each stretched pixel and
// compares it with the block's output. Depends on mmcs_pkg, mmcs_tb_pkg, mmcs_if.
module stretch_result_check
    import mmcs_pkg::*;
    import mmcs_tb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    mmcs_in_if               req_mon,
    mmcs_out_if              res_mon,
    output int               fail_count,
    output int               pending_count
);

    localparam int OUT_MAX = (1 << OUT_BITS) - 1;

    typedef struct packed {
        logic [OUT_BITS-1:0] norm_pixel;
        logic                frame_end;
    } stretch_res_t;

    logic [PIXEL_BITS-1:0] frame_mem [FRAME_DEPTH];
    logic [PIXEL_BITS-1:0] pix_lo;
    logic [PIXEL_BITS-1:0] pix_hi;
    int unsigned           loads_done;
    int unsigned           reads_done;
    logic [CFG_W-1:0]      count_reg;
    stretch_res_t          stretch_q [$];
    int                    fails = 0;

    function automatic int unsigned frame_size(input logic [CFG_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > FRAME_DEPTH)
            return FRAME_DEPTH;
        return c;
    endfunction

    function automatic logic [OUT_BITS-1:0] stretch_pixel(
        input logic [PIXEL_BITS-1:0] p,
        input logic [PIXEL_BITS-1:0] lo,
        input logic [PIXEL_BITS-1:0] hi
    );
        int unsigned span;
        int unsigned ofs;
        int unsigned q;
        if (hi <= lo)
            return '0;
        span = hi - lo;
        ofs  = (p > lo) ? p - lo : 0;
        q    = ofs * OUT_MAX / span;
        if (q > OUT_MAX)
            q = OUT_MAX;
        return q[OUT_BITS-1:0];
    endfunction

    function automatic void restart_frame();
        pix_lo     = '1;
        pix_hi     = '0;
        loads_done = 0;
        reads_done = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        stretch_res_t got;
        stretch_res_t want;
        int unsigned  n;
        if (!rst_n)
        begin
            count_reg = PIX_TOTAL_RESET;
            restart_frame();
            stretch_q.delete();
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                got = {res_mon.norm_pixel, res_mon.frame_end};
                if (stretch_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected item norm_pixel %0d frame_end %0b",
                                 $realtime, got.norm_pixel, got.frame_end);
                end
                else
                begin
                    want = stretch_q.pop_front();
                    if (got.norm_pixel !== want.norm_pixel ||
                        got.frame_end !== want.frame_end)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch pixel exp %0d got %0d, end exp %0b got %0b",
                                     $realtime, want.norm_pixel, got.norm_pixel,
                                     want.frame_end, got.frame_end);
                    end
                end
            end

            if (req_mon.valid && req_mon.ready)
            begin
                n = frame_size(count_reg);
                if (req_mon.req_type == REQ_LOAD)
                begin
                    if (loads_done < n)
                    begin
                        frame_mem[loads_done] = req_mon.pixel_in;
                        if (req_mon.pixel_in < pix_lo)
                            pix_lo = req_mon.pixel_in;
                        if (req_mon.pixel_in > pix_hi)
                            pix_hi = req_mon.pixel_in;
                        loads_done++;
                    end
                end
                else if (loads_done >= n)
                begin
                    want.norm_pixel = stretch_pixel(frame_mem[reads_done], pix_lo, pix_hi);
                    want.frame_end  = (reads_done >= n - 1);
                    stretch_q.push_back(want);
                    if (want.frame_end)
                        restart_frame();
                    else
                        reads_done++;
                end
            end

            if (cfg_we)
                count_reg = cfg_data;
        end
        fail_count    <= fails;
        pending_count <= stretch_q.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for min_max_contrast_stretch_top: clock, reset, request stimulus,
// result back-pressure and the verdict. Checking is done in stretch_result_check.
// Depends on mmcs_pkg, mmcs_tb_pkg, mmcs_if and the block's RTL.
module tb_top;
    import mmcs_pkg::*;
    import mmcs_tb_pkg::*;

    localparam int PIX_MAX = (1 << PIXEL_BITS) - 1;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    int chk_fails;
    int chk_pending;

    int idle_pct  = 0;
    int stall_pct = 0;

    // stimulus-side view of frame progress
    int frame_n  = FRAME_DEPTH;
    int loaded   = 0;
    int read_pos = 0;
    int useful   = 0;
    bit frame_done;

    mmcs_in_if  pix_req_ch ();
    mmcs_out_if stretch_res_ch ();

    min_max_contrast_stretch_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (pix_req_ch),
        .out_ch   (stretch_res_ch)
    );

    stretch_result_check u_stretch_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .req_mon       (pix_req_ch),
        .res_mon       (stretch_res_ch),
        .fail_count    (chk_fails),
        .pending_count (chk_pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        stretch_res_ch.ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_item(input logic rt, input logic [PIXEL_BITS-1:0] px);
        while ($urandom_range(99) < idle_pct)
        begin
            pix_req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_req_ch.valid    <= 1'b1;
        pix_req_ch.req_type <= rt;
        pix_req_ch.pixel_in <= px;
        @(posedge clk);
        while (!pix_req_ch.ready)
            @(posedge clk);
    endtask

    task automatic push_load(input logic [PIXEL_BITS-1:0] px);
        send_item(REQ_LOAD, px);
        if (loaded < frame_n)
        begin
            loaded++;
            useful++;
        end
    endtask

    task automatic push_read();
        send_item(REQ_READ, PIXEL_BITS'($urandom_range(PIX_MAX)));
        if (loaded >= frame_n)
        begin
            useful++;
            if (read_pos >= frame_n - 1)
            begin
                loaded     = 0;
                read_pos   = 0;
                frame_done = 1'b1;
            end
            else
                read_pos++;
        end
    endtask

    task automatic settle();
        pix_req_ch.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_count(input int v);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= v[CFG_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        frame_n = (v == 0) ? 1 : ((v > FRAME_DEPTH) ? FRAME_DEPTH : v);
    endtask

    task automatic finish_frame(input bit allow_resize);
        frame_done = 1'b0;
        while (!frame_done)
        begin
            if (allow_resize && read_pos > 0 && $urandom_range(29) == 0)
                set_count($urandom_range(1, frame_n));
            push_read();
        end
    endtask

    function automatic int pick_count();
        case ($urandom_range(15))
            0:       return 0;
            1:       return $urandom_range(17, 64);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick_pixel(input int mode, input int base);
        case (mode)
            0: return PIXEL_BITS'($urandom_range(PIX_MAX));
            1: return PIXEL_BITS'(base + $urandom_range(7));
            2: return PIXEL_BITS'(base);
            default:
                case ($urandom_range(2))
                    0:       return '0;
                    1:       return '1;
                    default: return PIXEL_BITS'($urandom_range(PIX_MAX));
                endcase
        endcase
    endfunction

    task automatic run_frame();
        int mode;
        int base;
        if ($urandom_range(3) == 0)
            set_count(pick_count());
        mode = $urandom_range(3);
        base = $urandom_range(PIX_MAX - 7);
        while (loaded < frame_n)
        begin
            if ($urandom_range(19) == 0)
                push_read();
            if ($urandom_range(39) == 0)
                set_count(pick_count());
            push_load(pick_pixel(mode, base));
        end
        if ($urandom_range(5) == 0)
            repeat ($urandom_range(1, 3)) push_load(pick_pixel(mode, base));
        finish_frame(1'b1);
    endtask

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int idle_mix [4]  = '{0, 84, 0, 26};
        int stall_mix [4] = '{0, 0, 84, 26};
        int goal;
        pix_req_ch.valid     <= 1'b0;
        pix_req_ch.req_type  <= REQ_LOAD;
        pix_req_ch.pixel_in  <= '0;
        cfg_we               <= 1'b0;
        cfg_data             <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero count, flat frames, extremes, ignored items, resize mid-read
        set_count(0);
        push_load('1);
        push_read();
        push_read();
        set_count(3);
        push_load('0);
        push_read();
        push_load('1);
        push_load(1);
        push_load(7);
        repeat (3) push_read();
        set_count(2);
        push_load(5);
        push_load(5);
        repeat (2) push_read();
        set_count(4);
        push_load(100);
        push_load(200);
        push_load(300);
        push_load(400);
        push_read();
        set_count(2);
        push_read();
        set_count(1);
        push_load(16'h8000);
        push_read();

        // oversized count with drops, then a shrink and a late resize
        set_count((1 << CFG_W) - 1);
        repeat (5) push_load(PIXEL_BITS'($urandom_range(PIX_MAX)));
        push_read();
        set_count(5);
        push_load('0);
        repeat (3) push_read();
        set_count(2);
        push_read();

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            idle_pct  = idle_mix[ph];
            stall_pct = stall_mix[ph];
            goal      = useful + 410;
            while (useful < goal)
                run_frame();
        end

        idle_pct  = 0;
        stall_pct = 0;
        settle();
        if (chk_fails == 0 && chk_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
